// ===== hw/rtl/poac_pkg.sv =====
// Shared types for the path ORAM access controller: datapath commands and status.
`timescale 1ns / 1ps

package poac_pkg;

   typedef enum logic [3:0] {
      CMD_NONE       = 4'd0,
      CMD_CLEAR      = 4'd1,
      CMD_LOAD       = 4'd2,
      CMD_REDUCE     = 4'd3,
      CMD_LEAF_UPD   = 4'd4,
      CMD_FETCH_RD   = 4'd5,
      CMD_FETCH_CHK  = 4'd6,
      CMD_SCAN       = 4'd7,
      CMD_FETCH_PUT  = 4'd8,
      CMD_FETCH_NEXT = 4'd9,
      CMD_ACC_INIT   = 4'd10,
      CMD_ACC_RD     = 4'd11,
      CMD_ACC_PUT    = 4'd12,
      CMD_EVICT      = 4'd13,
      CMD_EVICT_NEXT = 4'd14,
      CMD_RESP       = 4'd15
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic id_ok;
      logic tree_hit;
      logic scan_done;
      logic fetch_last;
      logic level_done;
      logic lvl_zero;
   } status_type;

endpackage

// ===== hw/rtl/poac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module poac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/poac_ctrl.sv =====
// Sequencer for the path ORAM access: clear pass, fetch, access, eviction, response.
`timescale 1ns / 1ps

module poac_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  poac_pkg::status_type status,
   output poac_pkg::cmd_type    cmd
);

   typedef enum logic [15:0] {
      S_CLEAR  = 16'h0001,
      S_IDLE   = 16'h0002,
      S_REDUCE = 16'h0004,
      S_LEAF   = 16'h0008,
      S_FRD    = 16'h0010,
      S_FCHK   = 16'h0020,
      S_FSCAN  = 16'h0040,
      S_FPUT   = 16'h0080,
      S_FNEXT  = 16'h0100,
      S_AINIT  = 16'h0200,
      S_ASCAN  = 16'h0400,
      S_ARD    = 16'h0800,
      S_APUT   = 16'h1000,
      S_EVICT  = 16'h2000,
      S_ENEXT  = 16'h4000,
      S_RESP   = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = poac_pkg::CMD_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd = poac_pkg::CMD_CLEAR;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd      = poac_pkg::CMD_LOAD;
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd = poac_pkg::CMD_REDUCE;
            if (status.id_ok) state_in = S_LEAF;
         end
         S_LEAF: begin
            cmd      = poac_pkg::CMD_LEAF_UPD;
            state_in = S_FRD;
         end
         S_FRD: begin
            cmd      = poac_pkg::CMD_FETCH_RD;
            state_in = S_FCHK;
         end
         S_FCHK: begin
            cmd      = poac_pkg::CMD_FETCH_CHK;
            state_in = status.tree_hit ? S_FSCAN : S_FNEXT;
         end
         S_FSCAN: begin
            cmd = poac_pkg::CMD_SCAN;
            if (status.scan_done) state_in = S_FPUT;
         end
         S_FPUT: begin
            cmd      = poac_pkg::CMD_FETCH_PUT;
            state_in = S_FNEXT;
         end
         S_FNEXT: begin
            cmd      = poac_pkg::CMD_FETCH_NEXT;
            state_in = status.fetch_last ? S_AINIT : S_FRD;
         end
         S_AINIT: begin
            cmd      = poac_pkg::CMD_ACC_INIT;
            state_in = S_ASCAN;
         end
         S_ASCAN: begin
            cmd = poac_pkg::CMD_SCAN;
            if (status.scan_done) state_in = S_ARD;
         end
         S_ARD: begin
            cmd      = poac_pkg::CMD_ACC_RD;
            state_in = S_APUT;
         end
         S_APUT: begin
            cmd      = poac_pkg::CMD_ACC_PUT;
            state_in = S_EVICT;
         end
         S_EVICT: begin
            cmd = poac_pkg::CMD_EVICT;
            if (status.level_done) state_in = S_ENEXT;
         end
         S_ENEXT: begin
            cmd      = poac_pkg::CMD_EVICT_NEXT;
            state_in = status.lvl_zero ? S_RESP : S_EVICT;
         end
         S_RESP: begin
            cmd      = poac_pkg::CMD_RESP;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hw/rtl/poac_dp.sv =====
// Datapath: position map, tree and stash stores, scan pipelines and result registers.
`timescale 1ns / 1ps

module poac_dp #(
   parameter int TREE_LEVELS   = 10,
   parameter int BUCKET_SLOTS  = 4,
   parameter int STASH_ENTRIES = 64,
   parameter int BLOCK_COUNT   = 1024,
   parameter int DATA_BITS     = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  poac_pkg::cmd_type    cmd,
   output poac_pkg::status_type status,
   input  logic                 req_op,
   input  logic [9:0]           req_block_id,
   input  logic [63:0]          req_write_data,
   input  logic [9:0]           req_new_leaf,
   output logic                 rsp_valid,
   output logic [63:0]          rsp_read_data,
   output logic                 rsp_stash_overflow,
   output logic [6:0]           rsp_stash_count
);

   localparam int LW      = TREE_LEVELS;
   localparam int NODES   = (2 << LW) - 1;
   localparam int SLOTS   = NODES * BUCKET_SLOTS;
   localparam int SAW     = $clog2(SLOTS);
   localparam int IW      = $clog2(BLOCK_COUNT);
   localparam int LVW     = $clog2(TREE_LEVELS + 1);
   localparam int ZW      = $clog2(BUCKET_SLOTS + 1);
   localparam int SIW     = $clog2(STASH_ENTRIES);
   localparam int SCW     = $clog2(STASH_ENTRIES + 1);
   localparam int CLR_LEN = (SLOTS > BLOCK_COUNT) ? SLOTS : BLOCK_COUNT;
   localparam int CLW     = $clog2(CLR_LEN);
   localparam int TW      = 1 + IW + DATA_BITS;
   localparam int SW      = IW + DATA_BITS;

   // slot address of slot z in the bucket at level lvl on the path to leaf
   function automatic logic [SAW-1:0] slot_addr(input logic [LW-1:0] leaf,
                                                input logic [LVW-1:0] lvl,
                                                input logic [ZW-1:0] z);
      logic [LW:0] pos;
      logic [LW:0] node;
      logic [31:0] addr;
      pos  = {1'b1, leaf};
      node = (pos >> (LVW'(LW) - lvl)) - 1'b1;
      addr = 32'(node) * 32'(BUCKET_SLOTS) + 32'(z);
      return addr[SAW-1:0];
   endfunction

   function automatic logic same_branch(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                        input logic [LVW-1:0] lvl);
      logic [LVW-1:0] sh;
      sh = LVW'(LW) - lvl;
      return (a >> sh) == (b >> sh);
   endfunction

   logic [CLW-1:0]        clr_ff, clr_in;
   logic                  op_ff, op_in;
   logic [9:0]            raw_ff, raw_in;
   logic [DATA_BITS-1:0]  wdata_ff, wdata_in;
   logic [LW-1:0]         nleaf_ff, nleaf_in;
   logic [LW-1:0]         old_leaf_ff, old_leaf_in;
   logic [LVW-1:0]        lvl_ff, lvl_in;
   logic [ZW-1:0]         z_ff, z_in;
   logic [IW-1:0]         tid_ff, tid_in;
   logic [DATA_BITS-1:0]  tdata_ff, tdata_in;
   logic [IW-1:0]         key_ff, key_in;
   logic [SCW-1:0]        s_ff, s_in;
   logic                  pend_ff, pend_in;
   logic [SIW-1:0]        pidx_ff, pidx_in;
   logic                  found_ff, found_in;
   logic [SIW-1:0]        hit_ff, hit_in;
   logic                  free_ok_ff, free_ok_in;
   logic [SIW-1:0]        free_ff, free_in;
   logic                  e2_ff, e2_in;
   logic [SIW-1:0]        e2_idx_ff, e2_idx_in;
   logic [IW-1:0]         e2_id_ff, e2_id_in;
   logic [DATA_BITS-1:0]  e2_data_ff, e2_data_in;
   logic [ZW-1:0]         placed_ff, placed_in;
   logic [STASH_ENTRIES-1:0] valid_ff, valid_in;
   logic [SCW-1:0]        cnt_ff, cnt_in;
   logic                  ovf_ff, ovf_in;
   logic [DATA_BITS-1:0]  rdata_ff, rdata_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  leaf_we;
   logic [IW-1:0]         leaf_wa, leaf_ra;
   logic [LW-1:0]         leaf_wd, leaf_rd;
   logic                  tree_we;
   logic [SAW-1:0]        tree_wa, tree_ra;
   logic [TW-1:0]         tree_wd, tree_rd;
   logic                  st_we;
   logic [SIW-1:0]        st_wa, st_ra;
   logic [SW-1:0]         st_wd, st_rd;

   logic [IW-1:0]         id;
   logic                  s_live;
   logic                  cur_valid;
   logic [SIW-1:0]        s_idx;
   logic [IW-1:0]         st_id;
   logic [IW-1:0]         tree_id;
   logic [SAW-1:0]        path_slot;

   assign id        = IW'(raw_ff);
   assign s_live    = 32'(s_ff) < 32'(STASH_ENTRIES);
   assign s_idx     = s_ff[SIW-1:0];
   assign cur_valid = s_live && valid_ff[s_idx];
   assign st_id     = st_rd[SW-1 -: IW];
   assign tree_id   = tree_rd[TW-2 -: IW];
   assign path_slot = slot_addr(old_leaf_ff, lvl_ff, z_ff);

   assign status.clr_last   = 32'(clr_ff) == 32'(CLR_LEN - 1);
   assign status.id_ok      = 32'(raw_ff) < 32'(BLOCK_COUNT);
   assign status.tree_hit   = tree_rd[TW-1];
   assign status.scan_done  = !s_live && !pend_ff;
   assign status.fetch_last = (32'(lvl_ff) == 32'(TREE_LEVELS)) &&
                              (32'(z_ff) == 32'(BUCKET_SLOTS - 1));
   assign status.level_done = (32'(placed_ff) == 32'(BUCKET_SLOTS)) ||
                              (!s_live && !pend_ff && !e2_ff);
   assign status.lvl_zero   = (lvl_ff == '0);

   always_comb begin
      clr_in      = clr_ff;
      op_in       = op_ff;
      raw_in      = raw_ff;
      wdata_in    = wdata_ff;
      nleaf_in    = nleaf_ff;
      old_leaf_in = old_leaf_ff;
      lvl_in      = lvl_ff;
      z_in        = z_ff;
      tid_in      = tid_ff;
      tdata_in    = tdata_ff;
      key_in      = key_ff;
      s_in        = s_ff;
      pend_in     = pend_ff;
      pidx_in     = pidx_ff;
      found_in    = found_ff;
      hit_in      = hit_ff;
      free_ok_in  = free_ok_ff;
      free_in     = free_ff;
      e2_in       = e2_ff;
      e2_idx_in   = e2_idx_ff;
      e2_id_in    = e2_id_ff;
      e2_data_in  = e2_data_ff;
      placed_in   = placed_ff;
      valid_in    = valid_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      rdata_in    = rdata_ff;
      rsp_valid_in = 1'b0;

      leaf_we = 1'b0;
      leaf_wa = id;
      leaf_wd = nleaf_ff;
      leaf_ra = id;
      tree_we = 1'b0;
      tree_wa = path_slot;
      tree_wd = '0;
      tree_ra = path_slot;
      st_we   = 1'b0;
      st_wa   = free_ff;
      st_wd   = {tid_ff, tdata_ff};
      st_ra   = s_idx;

      case (cmd)
         poac_pkg::CMD_CLEAR: begin
            leaf_we = 32'(clr_ff) < 32'(BLOCK_COUNT);
            leaf_wa = clr_ff[IW-1:0];
            leaf_wd = '0;
            tree_we = 32'(clr_ff) < 32'(SLOTS);
            tree_wa = clr_ff[SAW-1:0];
            clr_in  = clr_ff + 1'b1;
         end
         poac_pkg::CMD_LOAD: begin
            op_in    = req_op;
            raw_in   = req_block_id;
            wdata_in = DATA_BITS'(req_write_data);
            nleaf_in = LW'(req_new_leaf);
         end
         poac_pkg::CMD_REDUCE: begin
            if (!status.id_ok) raw_in = raw_ff - 10'(BLOCK_COUNT);
         end
         poac_pkg::CMD_LEAF_UPD: begin
            old_leaf_in = leaf_rd;
            leaf_we     = 1'b1;
            lvl_in      = '0;
            z_in        = '0;
         end
         poac_pkg::CMD_FETCH_CHK: begin
            tid_in     = tree_id;
            tdata_in   = tree_rd[DATA_BITS-1:0];
            key_in     = tree_id;
            s_in       = '0;
            pend_in    = 1'b0;
            found_in   = 1'b0;
            free_ok_in = 1'b0;
            tree_we    = 1'b1;   // every slot on the old path ends up a dummy
         end
         poac_pkg::CMD_SCAN: begin
            if (s_live) begin
               s_in    = s_ff + 1'b1;
               pend_in = cur_valid;
               pidx_in = s_idx;
               if (!valid_ff[s_idx] && !free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in    = s_idx;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && !found_ff && st_id == key_ff) begin
               found_in = 1'b1;
               hit_in   = pidx_ff;
            end
         end
         poac_pkg::CMD_FETCH_PUT: begin
            if (!found_ff) begin
               if (free_ok_ff) begin
                  st_we             = 1'b1;
                  valid_in[free_ff] = 1'b1;
                  cnt_in            = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         poac_pkg::CMD_FETCH_NEXT: begin
            if (32'(z_ff) == 32'(BUCKET_SLOTS - 1)) begin
               z_in   = '0;
               lvl_in = lvl_ff + 1'b1;
            end else begin
               z_in = z_ff + 1'b1;
            end
         end
         poac_pkg::CMD_ACC_INIT: begin
            key_in     = id;
            s_in       = '0;
            pend_in    = 1'b0;
            found_in   = 1'b0;
            free_ok_in = 1'b0;
         end
         poac_pkg::CMD_ACC_RD: begin
            st_ra = hit_ff;
         end
         poac_pkg::CMD_ACC_PUT: begin
            if (found_ff) begin
               rdata_in = st_rd[DATA_BITS-1:0];
               st_we    = op_ff;
               st_wa    = hit_ff;
               st_wd    = {id, wdata_ff};
            end else if (free_ok_ff) begin
               rdata_in          = '0;
               st_we             = 1'b1;
               st_wd             = {id, op_ff ? wdata_ff : DATA_BITS'(0)};
               valid_in[free_ff] = 1'b1;
               cnt_in            = cnt_ff + 1'b1;
            end else begin
               rdata_in = '0;
               ovf_in   = 1'b1;
            end
            lvl_in    = LVW'(TREE_LEVELS);
            s_in      = '0;
            pend_in   = 1'b0;
            e2_in     = 1'b0;
            placed_in = '0;
         end
         poac_pkg::CMD_EVICT: begin
            // stage 0: stash read; stage 1: leaf lookup; stage 2: place
            if (s_live) begin
               s_in    = s_ff + 1'b1;
               pend_in = cur_valid;
               pidx_in = s_idx;
            end else begin
               pend_in = 1'b0;
            end
            leaf_ra    = st_id;
            e2_in      = pend_ff;
            e2_idx_in  = pidx_ff;
            e2_id_in   = st_id;
            e2_data_in = st_rd[DATA_BITS-1:0];
            if (e2_ff && (32'(placed_ff) < 32'(BUCKET_SLOTS)) &&
                same_branch(leaf_rd, old_leaf_ff, lvl_ff)) begin
               tree_we             = 1'b1;
               tree_wa             = slot_addr(old_leaf_ff, lvl_ff, placed_ff);
               tree_wd             = {1'b1, e2_id_ff, e2_data_ff};
               valid_in[e2_idx_ff] = 1'b0;
               cnt_in              = cnt_ff - 1'b1;
               placed_in           = placed_ff + 1'b1;
            end
         end
         poac_pkg::CMD_EVICT_NEXT: begin
            lvl_in    = lvl_ff - 1'b1;
            s_in      = '0;
            pend_in   = 1'b0;
            e2_in     = 1'b0;
            placed_in = '0;
         end
         poac_pkg::CMD_RESP: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         e2_ff        <= 1'b0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         e2_ff        <= e2_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      raw_ff      <= raw_in;
      wdata_ff    <= wdata_in;
      nleaf_ff    <= nleaf_in;
      old_leaf_ff <= old_leaf_in;
      lvl_ff      <= lvl_in;
      z_ff        <= z_in;
      tid_ff      <= tid_in;
      tdata_ff    <= tdata_in;
      key_ff      <= key_in;
      s_ff        <= s_in;
      pidx_ff     <= pidx_in;
      found_ff    <= found_in;
      hit_ff      <= hit_in;
      free_ok_ff  <= free_ok_in;
      free_ff     <= free_in;
      e2_idx_ff   <= e2_idx_in;
      e2_id_ff    <= e2_id_in;
      e2_data_ff  <= e2_data_in;
      placed_ff   <= placed_in;
      rdata_ff    <= rdata_in;
   end

   poac_ram #(.WIDTH(LW), .DEPTH(BLOCK_COUNT)) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (leaf_wa),
      .wr_data (leaf_wd),
      .rd_addr (leaf_ra),
      .rd_data (leaf_rd)
   );

   poac_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_wa),
      .wr_data (tree_wd),
      .rd_addr (tree_ra),
      .rd_data (tree_rd)
   );

   poac_ram #(.WIDTH(SW), .DEPTH(STASH_ENTRIES)) u_stash_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_wa),
      .wr_data (st_wd),
      .rd_addr (st_ra),
      .rd_data (st_rd)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = 64'(rdata_ff);
   assign rsp_stash_overflow = ovf_ff;
   assign rsp_stash_count    = (32'(cnt_ff) > 32'd127) ? 7'd127 : 7'(cnt_ff);

endmodule

// ===== hw/rtl/path_oram_access_controller.sv =====
// Top level of the path ORAM access controller: sequencer plus datapath.
//
//   channel   ports                                        handshake
//   request   req_op, req_block_id, req_write_data,        start & !busy
//             req_new_leaf
//   response  rsp_read_data, rsp_stash_overflow,           rsp_valid, one cycle
//             rsp_stash_count
//
// After reset a clearing pass writes the position map and every tree slot; busy
// stays high. One transaction runs a stash lookup scan per real block fetched
// and a stash scan per level on eviction.
// The response strobe follows the transaction and cannot be stalled.
`timescale 1ns / 1ps

module path_oram_access_controller #(
   parameter int TREE_LEVELS   = 10,
   parameter int BUCKET_SLOTS  = 4,
   parameter int STASH_ENTRIES = 64,
   parameter int BLOCK_COUNT   = 1024,
   parameter int DATA_BITS     = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [9:0]  req_block_id,
   input  logic [63:0] req_write_data,
   input  logic [9:0]  req_new_leaf,
   output logic        rsp_valid,
   output logic [63:0] rsp_read_data,
   output logic        rsp_stash_overflow,
   output logic [6:0]  rsp_stash_count
);

   poac_pkg::cmd_type    cmd;
   poac_pkg::status_type status;

   poac_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   poac_dp #(
      .TREE_LEVELS   (TREE_LEVELS),
      .BUCKET_SLOTS  (BUCKET_SLOTS),
      .STASH_ENTRIES (STASH_ENTRIES),
      .BLOCK_COUNT   (BLOCK_COUNT),
      .DATA_BITS     (DATA_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_block_id       (req_block_id),
      .req_write_data     (req_write_data),
      .req_new_leaf       (req_new_leaf),
      .rsp_valid          (rsp_valid),
      .rsp_read_data      (rsp_read_data),
      .rsp_stash_overflow (rsp_stash_overflow),
      .rsp_stash_count    (rsp_stash_count)
   );

endmodule
